/* hdl/ccesc_pkg.sv */
// Shared types, constants and byte-level helper functions for the control-escaping
// UTF-8 transcoder. Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ccesc_pkg;

  // Input item: one raw byte of a text field plus its framing flags
  typedef struct packed {
    logic [7:0] in_byte;
    logic       utf8_input;
    logic       end_of_field;
    logic       empty_field;
  } in_item_t;

  // Output item: one byte of display text
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICTURES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM      = 1'b1;

  // Code points and characters
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_PIC_BASE    = 21'h002400;
  localparam logic [20:0] CP_PIC_DEL     = 21'h002421;
  localparam logic [7:0]  CH_CARET       = 8'h5E;
  localparam logic [7:0]  CH_QUESTION    = 8'h3F;
  localparam logic [7:0]  CH_DEL         = 8'h7F;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // accept an item
    logic decode;  // decode the next character of the run
    logic emit;    // write one byte to the output register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ld_hold;    // item at the input only extends a held sequence
    logic ld_empty;   // item at the input is an empty field
    logic run_more;   // bytes left in the run after the current character
    logic char_done;  // current output byte is the last of the character
    logic out_free;   // output register can take a byte this cycle
  } dp_sts_t;

  // UTF-8 encoding of one code point, first byte in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } utf8_enc_t;

  // Total sequence length announced by a byte, 1 unless it is a valid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & 8'hE0) == 8'hC0)      len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    return len;
  endfunction

  function automatic utf8_enc_t utf8_encode(input logic [20:0] cp);
    utf8_enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

  // ESC [ 2 m
  function automatic logic [7:0] esc_dim_byte(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd0:    v = 8'h1B;
      2'd1:    v = 8'h5B;
      2'd2:    v = 8'h32;
      default: v = 8'h6D;
    endcase
    return v;
  endfunction

  // ESC [ 0 m
  function automatic logic [7:0] esc_reset_byte(input logic [1:0] i);
    logic [7:0] v;
    case (i)
      2'd0:    v = 8'h1B;
      2'd1:    v = 8'h5B;
      2'd2:    v = 8'h30;
      default: v = 8'h6D;
    endcase
    return v;
  endfunction

  // "(empty)"
  localparam logic [3:0] EMPTY_LEN = 4'd7;

  function automatic logic [7:0] empty_text_byte(input logic [2:0] i);
    logic [7:0] v;
    case (i)
      3'd0:    v = 8'h28;
      3'd1:    v = 8'h65;
      3'd2:    v = 8'h6D;
      3'd3:    v = 8'h70;
      3'd4:    v = 8'h74;
      3'd5:    v = 8'h79;
      default: v = 8'h29;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ccesc_ctrl.sv */
// Sequencer of the transcoder: accepts items, steps the datapath through
// decode and byte emission. Depends on ccesc_pkg.
`timescale 1ns / 1ps

module ccesc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ccesc_pkg::dp_sts_t  sts_i,
  output ccesc_pkg::ctl_cmd_t cmd_o
);
  import ccesc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Commands follow from the state and the handshakes
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
    cmd_o.decode  = (state_q == ST_DECODE);
    cmd_o.emit    = (state_q == ST_EMIT) && sts_i.out_free;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (sts_i.ld_empty)     state_q <= ST_EMIT;
            else if (!sts_i.ld_hold) state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sts_i.out_free && sts_i.char_done) begin
            state_q <= sts_i.run_more ? ST_DECODE : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/ccesc_dpath.sv */
// Datapath of the transcoder: held sequence, run buffer, character decoder,
// renderer and output register. Depends on ccesc_pkg.
`timescale 1ns / 1ps

module ccesc_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ccesc_pkg::in_item_t            in_item_i,
  input  logic                           cfg_we_i,
  input  logic [ccesc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                           cfg_wdata_i,
  input  ccesc_pkg::ctl_cmd_t            cmd_i,
  output ccesc_pkg::dp_sts_t             sts_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output ccesc_pkg::out_item_t           out_item_o
);
  import ccesc_pkg::*;

  // Configuration
  logic pictures_q, dim_q;

  // Incomplete sequence carried between items
  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [2:0]      seq_len_q, seq_len_d;

  // Run being decoded, oldest byte in slot 0
  logic [3:0][7:0] buf_q, buf_d;
  logic [2:0]      run_n_q, run_n_d;
  logic            latin_q, latin_d;
  logic            text_q, text_d;

  // Rendered character
  logic [3:0][7:0] body_q, body_d;
  logic [2:0]      body_len_q, body_len_d;
  logic            wrap_q, wrap_d;
  logic [3:0]      idx_q, idx_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  // Load-side decisions
  logic [2:0] cnt;
  logic [2:0] need;
  logic       hold;

  always_comb begin
    cnt  = {1'b0, held_cnt_q} + 3'd1;
    need = (cnt == 3'd1) ? lead_length(in_item_i.in_byte) : seq_len_q;
    hold = in_item_i.utf8_input && !in_item_i.empty_field && !in_item_i.end_of_field &&
           (cnt < need) && (cnt <= 3'd3);
  end

  // Character decode at the head of the run
  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  hlen;
  logic [20:0] cp;
  logic [2:0]  adv;
  logic        is_ctrl;
  utf8_enc_t   enc;
  logic [20:0] pic_cp;

  always_comb begin
    b0   = buf_q[0];
    b1   = buf_q[1];
    b2   = buf_q[2];
    b3   = buf_q[3];
    hlen = lead_length(b0);
    adv  = 3'd1;
    if (latin_q || b0 < 8'h80) begin
      cp = {13'd0, b0};
    end else if (hlen == 3'd2 && run_n_q >= 3'd2) begin
      cp  = {10'd0, b0[4:0], b1[5:0]};
      adv = 3'd2;
    end else if (hlen == 3'd3 && run_n_q >= 3'd3) begin
      cp  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      adv = 3'd3;
    end else if (hlen == 3'd4 && run_n_q >= 3'd4) begin
      cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      adv = 3'd4;
    end else begin
      cp = CP_REPLACEMENT;
    end
    is_ctrl = (cp <= 21'd31) || (cp == {13'd0, CH_DEL});
    pic_cp  = (cp == {13'd0, CH_DEL}) ? CP_PIC_DEL : (CP_PIC_BASE | {16'd0, cp[4:0]});
    enc     = utf8_encode(is_ctrl ? pic_cp : cp);
  end

  // Emit-side byte selection
  logic [3:0] off, tail, last_idx;
  logic [7:0] cur_byte;
  logic       char_done;

  always_comb begin
    off  = idx_q - 4'd4;
    tail = off - {1'b0, body_len_q};
    if (text_q)      last_idx = EMPTY_LEN - 4'd1;
    else if (wrap_q) last_idx = {1'b0, body_len_q} + 4'd7;
    else             last_idx = {1'b0, body_len_q} - 4'd1;
    if (text_q) begin
      cur_byte = empty_text_byte(idx_q[2:0]);
    end else if (wrap_q) begin
      if (idx_q < 4'd4)                     cur_byte = esc_dim_byte(idx_q[1:0]);
      else if (off < {1'b0, body_len_q})    cur_byte = body_q[off[1:0]];
      else                                  cur_byte = esc_reset_byte(tail[1:0]);
    end else begin
      cur_byte = body_q[idx_q[1:0]];
    end
    char_done = (idx_q == last_idx);
  end

  // Status to the controller
  always_comb begin
    sts_o.ld_hold   = hold;
    sts_o.ld_empty  = in_item_i.empty_field;
    sts_o.run_more  = !text_q && (run_n_q != 3'd0);
    sts_o.char_done = char_done;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Next-state logic
  always_comb begin
    held_d      = held_q;
    held_cnt_d  = held_cnt_q;
    seq_len_d   = seq_len_q;
    buf_d       = buf_q;
    run_n_d     = run_n_q;
    latin_d     = latin_q;
    text_d      = text_q;
    body_d      = body_q;
    body_len_d  = body_len_q;
    wrap_d      = wrap_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      idx_d = '0;
      if (in_item_i.empty_field) begin
        held_cnt_d = '0;
        seq_len_d  = '0;
        text_d     = 1'b1;
        run_n_d    = '0;
      end else if (!in_item_i.utf8_input) begin
        held_cnt_d = '0;
        seq_len_d  = '0;
        buf_d[0]   = in_item_i.in_byte;
        run_n_d    = 3'd1;
        latin_d    = 1'b1;
        text_d     = 1'b0;
      end else if (hold) begin
        held_d[held_cnt_q] = in_item_i.in_byte;
        held_cnt_d         = cnt[1:0];
        seq_len_d          = need;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (k < 3 && k < int'(held_cnt_q)) buf_d[k] = held_q[k];
          else                               buf_d[k] = in_item_i.in_byte;
        end
        run_n_d    = cnt;
        latin_d    = 1'b0;
        text_d     = 1'b0;
        held_cnt_d = '0;
        seq_len_d  = '0;
      end
    end

    // Decode one character and render its body
    if (cmd_i.decode) begin
      idx_d   = '0;
      run_n_d = run_n_q - adv;
      case (adv)
        3'd1:    buf_d = {8'd0, buf_q[3], buf_q[2], buf_q[1]};
        3'd2:    buf_d = {16'd0, buf_q[3], buf_q[2]};
        3'd3:    buf_d = {24'd0, buf_q[3]};
        default: buf_d = '0;
      endcase
      wrap_d = is_ctrl && dim_q;
      if (is_ctrl && !pictures_q) begin
        body_d[0]  = CH_CARET;
        body_d[1]  = (cp == {13'd0, CH_DEL}) ? CH_QUESTION : {3'b010, cp[4:0]};
        body_d[2]  = 8'd0;
        body_d[3]  = 8'd0;
        body_len_d = 3'd2;
      end else begin
        body_d     = enc.bytes;
        body_len_d = enc.len;
      end
    end

    // One byte into the output register
    if (cmd_i.emit) begin
      out_d.out_byte = cur_byte;
      out_d.run_last = char_done && (text_q || run_n_q == 3'd0);
      out_valid_d    = 1'b1;
      idx_d          = idx_q + 4'd1;
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pictures_q  <= 1'b0;
      dim_q       <= 1'b0;
      held_q      <= '0;
      held_cnt_q  <= '0;
      seq_len_q   <= '0;
      buf_q       <= '0;
      run_n_q     <= '0;
      latin_q     <= 1'b0;
      text_q      <= 1'b0;
      body_q      <= '0;
      body_len_q  <= 3'd1;
      wrap_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PICTURES: pictures_q <= cfg_wdata_i;
          CFG_DIM:      dim_q      <= cfg_wdata_i;
          default:      ;
        endcase
      end
      held_q      <= held_d;
      held_cnt_q  <= held_cnt_d;
      seq_len_q   <= seq_len_d;
      buf_q       <= buf_d;
      run_n_q     <= run_n_d;
      latin_q     <= latin_d;
      text_q      <= text_d;
      body_q      <= body_d;
      body_len_q  <= body_len_d;
      wrap_q      <= wrap_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/control_char_escaping_utf8_transcoder_unit.sv */
// Top level of the control-escaping UTF-8 transcoder: controller plus datapath.
// Depends on ccesc_pkg, ccesc_ctrl and ccesc_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one byte of a
//   text field per item, with its mode and end-of-field flags. Output channel
//   (out_valid_o / out_stall_i / out_item_o) carries display-text bytes; run_last
//   marks the last byte that an input item produces. A byte that only extends an
//   incomplete UTF-8 sequence produces nothing; the sequencer stays idle.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
// Sequencing:
//   An item is accepted in the idle state; each decoded character then passes
//   through a decode step and one emit step per output byte, with the emit step
//   waiting while the output register cannot take a byte. The first result byte
//   is written by the emit step that follows the decode step, or by the first
//   emit step directly for an empty field, which has no decode step. Emission is
//   byte-serial through the single output register.
// Reset and stall:
//   Reset clears the held sequence, the configuration and the output register.
//   While the receiver stalls, the output byte holds and the sequencer waits; the
//   next item is accepted as soon as the last byte of the previous one sits in
//   the output register.
`timescale 1ns / 1ps

module control_char_escaping_utf8_transcoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ccesc_pkg::in_item_t             in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ccesc_pkg::out_item_t            out_item_o,
  input  logic                            cfg_we_i,
  input  logic [ccesc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                            cfg_wdata_i
);
  import ccesc_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ccesc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccesc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
